[rtl/stim_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table package
// Record layout, result status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package stim_pkg;

  localparam int NAME_BYTES = 20;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_MERGED   = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_READ_OK  = 3'd3;
  localparam logic [2:0] STAT_RANGE    = 3'd4;

  typedef struct packed {
    logic [63:0]        name_hi;
    logic [63:0]        name_mid;
    logic [31:0]        name_lo;
    logic [31:0]        price;
    logic signed [31:0] amount;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
  } rec_t;

  typedef struct packed {
    logic start;
    logic rd_ridx;
    logic res_range;
    logic res_read;
    logic probe;
    logic narrow;
    logic merge;
    logic res_full;
    logic shift_rd;
    logic shift_wr;
    logic insert;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic ridx_ok;
    logic search_open;
    logic full;
    logic shift_more;
    logic key_eq;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/sorted_table_insert_merge.sv]
// ----------------------------------------------------------------------------
// Sorted table with insert-or-merge
// Keeps records sorted by key; inserts, merges amounts or reads by index.
// ----------------------------------------------------------------------------
// Each input request is an insert-or-merge (operation 0) or an indexed read
// (operation 1); each produces exactly one result request. Requests are taken
// one at a time: in_stall is high from acceptance until the result has been
// moved into the output register, which then holds it until the receiver
// lets it go. A new request may be accepted while a result still waits.
// A read passes through S_RDWAIT to S_EMIT; a read out of range goes straight
// to S_EMIT. An insert runs a binary search with one record memory read per
// probe (about log2 of the entry count in probes), then moves each entry
// above the insert point up by a read and then a write, then writes the new
// record; a merge ends after its matching probe. The record memory has one
// read and one write port. Reset empties the table and sets key_mode to
// full-key order; stored records are not cleared. While out_stall is high
// the result and out_valid hold, and once the block has a second result
// ready it waits for them. The user must write key_mode through cfg_we and
// cfg_wdata only while the block is idle; the block leaves this to the user.
// ----------------------------------------------------------------------------
module sorted_table_insert_merge #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [63:0]        name_hi,
  input  logic [63:0]        name_mid,
  input  logic [31:0]        name_lo,
  input  logic [31:0]        price_cents,
  input  logic signed [31:0] amount_in,
  input  logic [4:0]         day_in,
  input  logic [3:0]         month_in,
  input  logic [13:0]        year_in,
  input  logic [4:0]         read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [5:0]         position,
  output logic [5:0]         entry_total,
  output logic [63:0]        out_name_hi,
  output logic [63:0]        out_name_mid,
  output logic [31:0]        out_name_lo,
  output logic [31:0]        out_price,
  output logic signed [31:0] out_amount,
  output logic [4:0]         out_day,
  output logic [3:0]         out_month,
  output logic [13:0]        out_year
);

  stim_pkg::ctrl_cmd_t cmd;
  stim_pkg::dp_stat_t  st;

  stim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  stim_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .operation    (operation),
    .name_hi      (name_hi),
    .name_mid     (name_mid),
    .name_lo      (name_lo),
    .price_cents  (price_cents),
    .amount_in    (amount_in),
    .day_in       (day_in),
    .month_in     (month_in),
    .year_in      (year_in),
    .read_index   (read_index),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .position     (position),
    .entry_total  (entry_total),
    .out_name_hi  (out_name_hi),
    .out_name_mid (out_name_mid),
    .out_name_lo  (out_name_lo),
    .out_price    (out_price),
    .out_amount   (out_amount),
    .out_day      (out_day),
    .out_month    (out_month),
    .out_year     (out_year)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a request without going busy");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.merge, cmd.shift_wr, cmd.insert}))
    else $error("more than one record write in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result loaded over a held output");
`endif

endmodule

[rtl/stim_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/stim_dp.sv]
// ----------------------------------------------------------------------------
// Sorted table datapath
// Search bounds, key compare, saturating merge, shift addressing, result
// and output registers around the record memory.
// ----------------------------------------------------------------------------
module stim_dp #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  stim_pkg::ctrl_cmd_t cmd,
  output stim_pkg::dp_stat_t  st,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                operation,
  input  logic [63:0]         name_hi,
  input  logic [63:0]         name_mid,
  input  logic [31:0]         name_lo,
  input  logic [31:0]         price_cents,
  input  logic signed [31:0]  amount_in,
  input  logic [4:0]          day_in,
  input  logic [3:0]          month_in,
  input  logic [13:0]         year_in,
  input  logic [4:0]          read_index,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          status,
  output logic [5:0]          position,
  output logic [5:0]          entry_total,
  output logic [63:0]         out_name_hi,
  output logic [63:0]         out_name_mid,
  output logic [31:0]         out_name_lo,
  output logic [31:0]         out_price,
  output logic signed [31:0]  out_amount,
  output logic [4:0]          out_day,
  output logic [3:0]          out_month,
  output logic [13:0]         out_year
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $bits(stim_pkg::rec_t);

  logic              key_mode;
  logic [CW-1:0]     count;
  logic [CW-1:0]     low;
  logic [CW-1:0]     high;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     idx;
  logic [4:0]        ridx;
  stim_pkg::rec_t    key;
  logic [2:0]        res_status;
  logic [CW-1:0]     res_pos;
  logic [CW-1:0]     res_total;
  stim_pkg::rec_t    res_rec;

  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid_c;
  logic [CW+4:0]     ridx_in_ext;
  logic [CW+4:0]     ridx_ext;
  logic [CW-1:0]     ridx_in_c;
  logic [CW-1:0]     ridx_c;
  logic [CW+5:0]     pos_ext;
  logic [CW+5:0]     tot_ext;
  logic [CW-1:0]     idx_dec;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  stim_pkg::rec_t    ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [RW-1:0]     ram_rdata;
  stim_pkg::rec_t    ent;
  stim_pkg::rec_t    merged;

  logic [159:0]      name_a;
  logic [159:0]      name_b;
  logic [7:0]        byte_a;
  logic [7:0]        byte_b;
  logic              name_done;
  logic              name_lt;
  logic              name_gt;
  logic [22:0]       date_a;
  logic [22:0]       date_b;
  logic              key_lt;
  logic              key_gt;
  logic [32:0]       sum;
  logic signed [31:0] sat;

  assign ent         = stim_pkg::rec_t'(ram_rdata);
  assign mid_sum     = {1'b0, low} + {1'b0, high};
  assign mid_c       = mid_sum[CW:1];
  assign ridx_in_ext = {{CW{1'b0}}, read_index};
  assign ridx_in_c   = ridx_in_ext[CW-1:0];
  assign idx_dec     = idx - 1'b1;

  always_comb begin
    ridx_ext = {{CW{1'b0}}, ridx};
  end

  assign ridx_c = ridx_ext[CW-1:0];

  // Name order follows a C string compare: first differing byte, or a zero
  // byte that both names share, decides.
  always_comb begin
    name_a    = {key.name_hi, key.name_mid, key.name_lo};
    name_b    = {ent.name_hi, ent.name_mid, ent.name_lo};
    name_done = 1'b0;
    name_lt   = 1'b0;
    name_gt   = 1'b0;
    byte_a    = '0;
    byte_b    = '0;
    for (int i = 0; i < stim_pkg::NAME_BYTES; i++) begin
      byte_a = name_a[159 - 8 * i -: 8];
      byte_b = name_b[159 - 8 * i -: 8];
      if (!name_done) begin
        if (byte_a != byte_b) begin
          name_lt   = byte_a < byte_b;
          name_gt   = byte_a > byte_b;
          name_done = 1'b1;
        end else if (byte_a == 8'd0) begin
          name_done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    date_a = {key.year, key.month, key.day};
    date_b = {ent.year, ent.month, ent.day};
    if (!key_mode && (name_lt || name_gt)) begin
      key_lt = name_lt;
      key_gt = name_gt;
    end else if (!key_mode && key.price != ent.price) begin
      key_lt = key.price < ent.price;
      key_gt = key.price > ent.price;
    end else begin
      key_lt = date_a < date_b;
      key_gt = date_a > date_b;
    end
  end

  always_comb begin
    sum    = {ent.amount[31], ent.amount} + {key.amount[31], key.amount};
    sat    = sum[31:0];
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    merged        = ent;
    merged.amount = sat;
  end

  always_comb begin
    ram_we    = cmd.merge || cmd.shift_wr || cmd.insert;
    ram_waddr = low[AW-1:0];
    ram_wdata = key;
    if (cmd.merge) begin
      ram_waddr = mid[AW-1:0];
      ram_wdata = merged;
    end else if (cmd.shift_wr) begin
      ram_waddr = idx[AW-1:0];
      ram_wdata = ent;
    end
    ram_raddr = idx_dec[AW-1:0];
    if (cmd.rd_ridx) begin
      ram_raddr = ridx_in_c[AW-1:0];
    end else if (cmd.probe) begin
      ram_raddr = mid_c[AW-1:0];
    end
  end

  stim_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= 1'b0;
      count    <= '0;
    end else begin
      if (cfg_we) begin
        key_mode <= cfg_wdata;
      end
      if (cmd.insert) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key  <= '{name_hi, name_mid, name_lo, price_cents, amount_in,
                year_in, month_in, day_in};
      ridx <= read_index;
      low  <= '0;
      high <= count;
      idx  <= count;
    end
    if (cmd.probe) begin
      mid <= mid_c;
    end
    if (cmd.narrow) begin
      if (key_lt) begin
        high <= mid;
      end else begin
        low <= mid + 1'b1;
      end
    end
    if (cmd.shift_wr) begin
      idx <= idx_dec;
    end
    if (cmd.res_range) begin
      res_status <= stim_pkg::STAT_RANGE;
      res_pos    <= ridx_in_c;
      res_total  <= count;
      res_rec    <= '0;
    end
    if (cmd.res_read) begin
      res_status <= stim_pkg::STAT_READ_OK;
      res_pos    <= ridx_c;
      res_total  <= count;
      res_rec    <= ent;
    end
    if (cmd.merge) begin
      res_status <= stim_pkg::STAT_MERGED;
      res_pos    <= mid;
      res_total  <= count;
      res_rec    <= merged;
    end
    if (cmd.res_full) begin
      res_status <= stim_pkg::STAT_FULL;
      res_pos    <= low;
      res_total  <= count;
      res_rec    <= '0;
    end
    if (cmd.insert) begin
      res_status <= stim_pkg::STAT_INSERTED;
      res_pos    <= low;
      res_total  <= count + 1'b1;
      res_rec    <= key;
    end
  end

  assign pos_ext = {6'd0, res_pos};
  assign tot_ext = {6'd0, res_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= res_status;
      position     <= pos_ext[5:0];
      entry_total  <= tot_ext[5:0];
      out_name_hi  <= res_rec.name_hi;
      out_name_mid <= res_rec.name_mid;
      out_name_lo  <= res_rec.name_lo;
      out_price    <= res_rec.price;
      out_amount   <= res_rec.amount;
      out_day      <= res_rec.day;
      out_month    <= res_rec.month;
      out_year     <= res_rec.year;
    end
  end

  always_comb begin
    st.is_read     = operation;
    st.ridx_ok     = ridx_in_ext < {5'd0, count};
    st.search_open = low < high;
    st.full        = count == CW'(TABLE_DEPTH);
    st.shift_more  = idx > low;
    st.key_eq      = !key_lt && !key_gt;
    st.out_free    = !out_valid || !out_stall;
  end

endmodule

[rtl/stim_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted table controller
// Sequences the binary search, the merge, the shift-up and the indexed read.
// ----------------------------------------------------------------------------
module stim_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  stim_pkg::dp_stat_t  st,
  output stim_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDWAIT = 7'b0000010,
    S_PROBE  = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_SHRD   = 7'b0010000,
    S_SHWR   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (!st.is_read) begin
            state_next = S_PROBE;
          end else if (st.ridx_ok) begin
            cmd.rd_ridx = 1'b1;
            state_next  = S_RDWAIT;
          end else begin
            cmd.res_range = 1'b1;
            state_next    = S_EMIT;
          end
        end
      end
      S_RDWAIT: begin
        cmd.res_read = 1'b1;
        state_next   = S_EMIT;
      end
      S_PROBE: begin
        if (st.search_open) begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end else if (st.full) begin
          cmd.res_full = 1'b1;
          state_next   = S_EMIT;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_CMP: begin
        if (st.key_eq) begin
          cmd.merge  = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_SHRD: begin
        if (st.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHWR;
        end else begin
          cmd.insert = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHRD;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[tb/sorted_table_insert_merge_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table insert-merge testbench
// Drives insert and read requests with random idling on both sides, predicts
// every result from a behavioral copy of the sorted table and compares each
// whole result at once. The key mode is changed between phases while idle.
// ----------------------------------------------------------------------------
module sorted_table_insert_merge_tb;

  localparam int DEPTH = 32;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;
  localparam logic MODE_FULL_KEY = 1'b0;
  localparam logic MODE_DATE     = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] nhi;
    logic [63:0] nmid;
    logic [31:0] nlo;
    logic [31:0] price;
    logic [31:0] amount;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  ridx;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  pos;
    logic [5:0]  total;
    logic [63:0] nhi;
    logic [63:0] nmid;
    logic [31:0] nlo;
    logic [31:0] price;
    logic [31:0] amount;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } result_t;

  logic clk, rst;
  logic cfg_we, cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic operation;
  logic [63:0] name_hi, name_mid;
  logic [31:0] name_lo, price_cents;
  logic signed [31:0] amount_in;
  logic [4:0] day_in, read_index;
  logic [3:0] month_in;
  logic [13:0] year_in;
  logic [2:0] status;
  logic [5:0] position, entry_total;
  logic [63:0] out_name_hi, out_name_mid;
  logic [31:0] out_name_lo, out_price;
  logic signed [31:0] out_amount;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [13:0] out_year;

  sorted_table_insert_merge dut (.*);

  request_t       pending_q[$];
  result_t        expected_q[$];
  logic           table_mode;
  int             table_count;
  stim_pkg::rec_t table_rec[DEPTH];
  int             errors = 0;
  bit             quiet_tail = 0;
  bit             hold_sender = 0;
  int             in_gap = 0, out_gap = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [22:0] date_key(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    return {y, m, d};
  endfunction

  function automatic logic [7:0] name_byte(logic [159:0] n, int i);
    return n[159 - 8 * i -: 8];
  endfunction

  function automatic int key_order(request_t r, stim_pkg::rec_t e);
    logic [159:0] a, b;
    logic [22:0] da, db;
    a = {r.nhi, r.nmid, r.nlo};
    b = {e.name_hi, e.name_mid, e.name_lo};
    if (table_mode == MODE_FULL_KEY) begin
      for (int i = 0; i < stim_pkg::NAME_BYTES; i++) begin
        if (name_byte(a, i) != name_byte(b, i))
          return name_byte(a, i) < name_byte(b, i) ? -1 : 1;
        if (name_byte(a, i) == 8'd0) break;
      end
      if (r.price != e.price) return r.price < e.price ? -1 : 1;
    end
    da = date_key(r.year, r.month, r.day);
    db = date_key(e.year, e.month, e.day);
    if (da != db) return da < db ? -1 : 1;
    return 0;
  endfunction

  function automatic result_t entry_result(logic [2:0] st, int p, stim_pkg::rec_t e);
    result_t x;
    x.status = st;
    x.pos = p[5:0];
    x.total = table_count[5:0];
    x.nhi = e.name_hi;
    x.nmid = e.name_mid;
    x.nlo = e.name_lo;
    x.price = e.price;
    x.amount = e.amount;
    x.day = e.day;
    x.month = e.month;
    x.year = e.year;
    return x;
  endfunction

  function automatic result_t table_apply(request_t r);
    int lo, hi, m, c;
    longint s;
    stim_pkg::rec_t e;
    if (r.op == OP_READ) begin
      if (int'(r.ridx) < table_count)
        return entry_result(stim_pkg::STAT_READ_OK, int'(r.ridx), table_rec[r.ridx]);
      return entry_result(stim_pkg::STAT_RANGE, int'(r.ridx), '0);
    end
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      m = lo + (hi - lo) / 2;
      c = key_order(r, table_rec[m]);
      if (c == 0) begin
        s = longint'(table_rec[m].amount) + longint'($signed(r.amount));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        table_rec[m].amount = s[31:0];
        return entry_result(stim_pkg::STAT_MERGED, m, table_rec[m]);
      end
      if (c < 0) hi = m;
      else lo = m + 1;
    end
    if (table_count >= DEPTH) return entry_result(stim_pkg::STAT_FULL, lo, '0);
    for (int i = table_count; i > lo; i--) table_rec[i] = table_rec[i - 1];
    e.name_hi = r.nhi;
    e.name_mid = r.nmid;
    e.name_lo = r.nlo;
    e.price = r.price;
    e.amount = r.amount;
    e.year = r.year;
    e.month = r.month;
    e.day = r.day;
    table_rec[lo] = e;
    table_count++;
    return entry_result(stim_pkg::STAT_INSERTED, lo, e);
  endfunction

  // Names drawn from a small pool so that merges and ties are frequent.
  function automatic request_t random_insert();
    request_t r;
    logic [159:0] n;
    int len;
    r.op = OP_INSERT;
    case ($urandom_range(0, 3))
      0: n = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      default: begin
        n = '0;
        len = $urandom_range(0, 20);
        for (int i = 0; i < len; i++) n[159 - 8 * i -: 8] = 8'($urandom_range(65, 68));
        if ($urandom_range(0, 5) == 0) n[159 - 8 * $urandom_range(0, 19) -: 8] = 8'($urandom());
      end
    endcase
    {r.nhi, r.nmid, r.nlo} = n;
    r.price = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3);
    r.amount = $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 20)) - 10);
    if ($urandom_range(0, 7) == 0) begin
      r.day = 5'($urandom());
      r.month = 4'($urandom());
      r.year = 14'($urandom());
    end else begin
      r.day = 5'($urandom_range(1, 3));
      r.month = 4'($urandom_range(1, 2));
      r.year = 14'($urandom_range(2020, 2021));
    end
    r.ridx = 5'($urandom());
    return r;
  endfunction

  function automatic request_t random_read();
    request_t r;
    r = random_insert();
    r.op = OP_READ;
    r.ridx = 5'($urandom());
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) void'(pending_q.pop_front());
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (!hold_sender && pending_q.size() > 0) begin
        request_t r;
        r = pending_q[0];
        in_valid <= 1'b1;
        operation <= r.op;
        name_hi <= r.nhi;
        name_mid <= r.nmid;
        name_lo <= r.nlo;
        price_cents <= r.price;
        amount_in <= r.amount;
        day_in <= r.day;
        month_in <= r.month;
        year_in <= r.year;
        read_index <= r.ridx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      request_t r;
      r = {operation, name_hi, name_mid, name_lo, price_cents, amount_in,
           day_in, month_in, year_in, read_index};
      expected_q.push_back(table_apply(r));
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_t got, want;
        got = {status, position, entry_total, out_name_hi, out_name_mid, out_name_lo,
               out_price, out_amount, out_day, out_month, out_year};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    table_mode = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_phase();
    request_t r;
    r = random_insert();
    r.op = OP_READ;
    r.ridx = 5'd0;
    pending_q.push_back(r);
    r.ridx = 5'd31;
    pending_q.push_back(r);
    r = random_insert();
    {r.nhi, r.nmid, r.nlo} = '1;
    r.price = '1;
    r.amount = 32'h7fffffff;
    r.day = 5'd31; r.month = 4'd15; r.year = 14'h3fff;
    pending_q.push_back(r);
    r.amount = 32'd5;
    pending_q.push_back(r);
    r.amount = 32'h80000000;
    pending_q.push_back(r);
    pending_q.push_back(r);
    pending_q.push_back(r);
    r = random_insert();
    {r.nhi, r.nmid, r.nlo} = '0;
    r.price = '0;
    r.day = 5'd0; r.month = 4'd0; r.year = 14'd0;
    pending_q.push_back(r);
    r.nmid = 64'hffff;
    pending_q.push_back(r);
    r = random_read();
    r.ridx = 5'd1;
    pending_q.push_back(r);
  endtask

  task automatic fill_phase(int n, int read_pct);
    for (int i = 0; i < n; i++)
      pending_q.push_back($urandom_range(0, 99) < read_pct ? random_read() : random_insert());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_wdata = 1'b0;
    in_valid = 1'b0; out_stall = 1'b0; operation = 1'b0;
    name_hi = '0; name_mid = '0; name_lo = '0; price_cents = '0; amount_in = '0;
    day_in = '0; month_in = '0; year_in = '0; read_index = '0;
    table_mode = MODE_FULL_KEY;
    table_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_phase();
    fill_phase(300, 30);
    drain();
    set_mode(MODE_DATE);
    fill_phase(300, 30);
    repeat (200) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    drain();
    fill_phase(200, 30);
    drain();
    set_mode(MODE_FULL_KEY);
    fill_phase(500, 25);
    drain();
    set_mode(MODE_DATE);
    fill_phase(300, 40);
    drain();
    set_mode(MODE_FULL_KEY);
    quiet_tail = 1'b1;
    fill_phase(240, 30);
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/stim_pkg.sv
rtl/stim_ram.sv
rtl/stim_dp.sv
rtl/stim_ctrl.sv
rtl/sorted_table_insert_merge.sv
tb/sorted_table_insert_merge_tb.sv
